[rtl/imhq_pkg.sv]
// shared constants, codes and types of the indexed min-heap queue
package imhq_pkg;

	localparam int CAPACITY     = 64;
	localparam int HANDLE_COUNT = 64;
	localparam int KEY_W        = 32;
	localparam int SLOT_W       = $clog2(CAPACITY);
	localparam int HANDLE_W     = $clog2(HANDLE_COUNT);
	localparam int CNT_W        = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_NOTQ  = 3'd2,
		ST_FULL  = 3'd3,
		ST_DUP   = 3'd4
	} status_t;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_POP_ROOT = 12'b0000_0000_0010,
		S_POP_LAST = 12'b0000_0000_0100,
		S_RM_POS   = 12'b0000_0000_1000,
		S_RM_LAST  = 12'b0000_0001_0000,
		S_UP_RD    = 12'b0000_0010_0000,
		S_UP_CMP   = 12'b0000_0100_0000,
		S_DN_CHK   = 12'b0000_1000_0000,
		S_DN_L     = 12'b0001_0000_0000,
		S_DN_R     = 12'b0010_0000_0000,
		S_DN_CMP   = 12'b0100_0000_0000,
		S_FIN      = 12'b1000_0000_0000
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] hdl;
	} entry_t;

endpackage

[rtl/imhq_ram.sv]
// simple dual-port ram, one write and one registered read per cycle
module imhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/indexed_min_heap_queue.sv]
// indexed min-heap priority queue top level with its sift sequencer
//
// input channel: in_valid / in_stall carries one word of operation, new_key and
// handle. push inserts a key under a handle, pop returns the smallest key and
// its handle, remove deletes the entry held by a handle.
// output channel: out_valid / out_stall carries one word per input word:
// status, out_key, out_handle and count (entries after the operation).
// a word is taken at a rising edge with valid high and stall low.
// one operation at a time: in_stall is high from acceptance until the result
// word is registered, and also while a result word waits under out_stall.
// rejected or trivial operations answer from idle, without a sift. push reads
// the parent and compares for each level climbed; pop and remove read the left
// and right child and compare for each level sunk (a remove may climb instead),
// the worst case being a refill that sinks from the root of a full queue; the
// heap ram gives one registered read per cycle, which paces the sift. the next
// word can be taken at the edge where the result word leaves.
// reset empties the queue at once: a valid bit per handle marks it queued,
// so no clearing pass is needed and the first word is taken right after.
// a stalled result word holds steady until taken.
module indexed_min_heap_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic signed [imhq_pkg::KEY_W-1:0] new_key,
	input  logic [imhq_pkg::HANDLE_W-1:0]     handle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic signed [imhq_pkg::KEY_W-1:0] out_key,
	output logic [imhq_pkg::HANDLE_W-1:0]     out_handle,
	output logic [imhq_pkg::CNT_W-1:0]        count
);

	localparam int SW = imhq_pkg::SLOT_W;
	localparam int HW = imhq_pkg::HANDLE_W;
	localparam int CW = imhq_pkg::CNT_W;
	localparam int KW = imhq_pkg::KEY_W;

	// control state
	imhq_pkg::state_t state_q, state_d;
	logic [CW-1:0]                    count_q, count_d;
	logic [imhq_pkg::HANDLE_COUNT-1:0] vld_q, vld_d;   // handle is queued
	logic                             ov_q, ov_d;

	// working registers of the sift: moving entry, hole slot, best child
	logic [SW-1:0]        slot_q, slot_d;
	logic signed [KW-1:0] mk_q, mk_d;
	logic [HW-1:0]        mh_q, mh_d;
	logic signed [KW-1:0] ck_q, ck_d;
	logic [HW-1:0]        ch_q, ch_d;
	logic [SW-1:0]        cidx_q, cidx_d;
	logic                 first_q, first_d;   // first compare of a remove

	// result word
	imhq_pkg::status_t    st_q, st_d;
	logic signed [KW-1:0] ok_q, ok_d;
	logic [HW-1:0]        oh_q, oh_d;

	// memory ports
	logic               hwe, pwe;
	logic [SW-1:0]      hwa, hra;
	imhq_pkg::entry_t   hwd, hrd;
	logic [HW-1:0]      pwa;
	logic [SW-1:0]      pwd, prd;

	logic          accept, take;
	logic [CW-1:0] cnt_m1;
	logic [SW-1:0] par;
	logic [CW-1:0] left, right;

	assign in_stall = (state_q != imhq_pkg::S_IDLE) || (ov_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign take     = ov_q && !out_stall;

	assign cnt_m1 = count_q - CW'(1);
	assign par    = (slot_q - SW'(1)) >> 1;
	assign left   = {slot_q, 1'b1};
	assign right  = left + CW'(1);

	// heap store: key and handle per slot
	imhq_ram #(
		.WIDTH($bits(imhq_pkg::entry_t)),
		.DEPTH(imhq_pkg::CAPACITY)
	) u_heap (
		.clk  (clk),
		.we   (hwe),
		.waddr(hwa),
		.wdata(hwd),
		.raddr(hra),
		.rdata(hrd)
	);

	// slot of each handle, read at the handle given with the word
	imhq_ram #(
		.WIDTH(SW),
		.DEPTH(imhq_pkg::HANDLE_COUNT)
	) u_pos (
		.clk  (clk),
		.we   (pwe),
		.waddr(pwa),
		.wdata(pwd),
		.raddr(handle),
		.rdata(prd)
	);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		vld_d   = vld_q;
		ov_d    = ov_q;
		slot_d  = slot_q;
		mk_d    = mk_q;
		mh_d    = mh_q;
		ck_d    = ck_q;
		ch_d    = ch_q;
		cidx_d  = cidx_q;
		first_d = first_q;
		st_d    = st_q;
		ok_d    = ok_q;
		oh_d    = oh_q;
		hwe     = 1'b0;
		hwa     = slot_q;
		hwd     = {mk_q, mh_q};
		pwe     = 1'b0;
		pwa     = mh_q;
		pwd     = slot_q;
		hra     = '0;

		if (take) begin
			ov_d = 1'b0;
		end

		case (state_q)
			imhq_pkg::S_IDLE: begin
				// root read is issued here for a pop
				if (accept) begin
					ok_d    = '0;
					oh_d    = '0;
					st_d    = imhq_pkg::ST_OK;
					mh_d    = handle;
					mk_d    = new_key;
					first_d = 1'b0;
					case (operation)
						imhq_pkg::OP_PUSH: begin
							if (vld_q[handle]) begin
								st_d = imhq_pkg::ST_DUP;
								ov_d = 1'b1;
							end else if (count_q == CW'(imhq_pkg::CAPACITY)) begin
								st_d = imhq_pkg::ST_FULL;
								ov_d = 1'b1;
							end else begin
								slot_d  = count_q[SW-1:0];
								count_d = count_q + CW'(1);
								state_d = (count_q == '0) ? imhq_pkg::S_FIN
								                          : imhq_pkg::S_UP_RD;
							end
						end
						imhq_pkg::OP_POP: begin
							if (count_q == '0) begin
								st_d = imhq_pkg::ST_EMPTY;
								ov_d = 1'b1;
							end else begin
								state_d = imhq_pkg::S_POP_ROOT;
							end
						end
						imhq_pkg::OP_REMOVE: begin
							if (!vld_q[handle]) begin
								st_d = imhq_pkg::ST_NOTQ;
								ov_d = 1'b1;
							end else begin
								state_d = imhq_pkg::S_RM_POS;
							end
						end
						default: begin
							ov_d = 1'b1;
						end
					endcase
				end
			end
			imhq_pkg::S_POP_ROOT: begin
				// root word is the answer; fetch the last entry
				ok_d             = hrd.key;
				oh_d             = hrd.hdl;
				vld_d[hrd.hdl]   = 1'b0;
				count_d          = cnt_m1;
				hra              = cnt_m1[SW-1:0];
				if (cnt_m1 == '0) begin
					ov_d    = 1'b1;
					state_d = imhq_pkg::S_IDLE;
				end else begin
					state_d = imhq_pkg::S_POP_LAST;
				end
			end
			imhq_pkg::S_POP_LAST: begin
				mk_d    = hrd.key;
				mh_d    = hrd.hdl;
				slot_d  = '0;
				state_d = imhq_pkg::S_DN_CHK;
			end
			imhq_pkg::S_RM_POS: begin
				// hole at the handle's slot; last entry refills it
				slot_d      = prd;
				vld_d[mh_q] = 1'b0;
				count_d     = cnt_m1;
				hra         = cnt_m1[SW-1:0];
				if ({1'b0, prd} == cnt_m1) begin
					ov_d    = 1'b1;
					state_d = imhq_pkg::S_IDLE;
				end else begin
					state_d = imhq_pkg::S_RM_LAST;
				end
			end
			imhq_pkg::S_RM_LAST: begin
				mk_d = hrd.key;
				mh_d = hrd.hdl;
				hra  = par;
				if (slot_q == '0) begin
					state_d = imhq_pkg::S_DN_CHK;
				end else begin
					first_d = 1'b1;
					state_d = imhq_pkg::S_UP_CMP;
				end
			end
			imhq_pkg::S_UP_RD: begin
				hra     = par;
				state_d = imhq_pkg::S_UP_CMP;
			end
			imhq_pkg::S_UP_CMP: begin
				first_d = 1'b0;
				if ($signed(mk_q) < $signed(hrd.key)) begin
					// parent moves down into the hole
					hwe     = 1'b1;
					hwd     = hrd;
					pwe     = 1'b1;
					pwa     = hrd.hdl;
					slot_d  = par;
					state_d = (par == '0) ? imhq_pkg::S_FIN : imhq_pkg::S_UP_RD;
				end else begin
					state_d = first_q ? imhq_pkg::S_DN_CHK : imhq_pkg::S_FIN;
				end
			end
			imhq_pkg::S_DN_CHK: begin
				hra = left[SW-1:0];
				if ({1'b0, slot_q} < (count_q >> 1)) begin
					state_d = imhq_pkg::S_DN_L;
				end else begin
					state_d = imhq_pkg::S_FIN;
				end
			end
			imhq_pkg::S_DN_L: begin
				ck_d   = hrd.key;
				ch_d   = hrd.hdl;
				cidx_d = left[SW-1:0];
				hra    = right[SW-1:0];
				if (right < count_q) begin
					state_d = imhq_pkg::S_DN_R;
				end else begin
					state_d = imhq_pkg::S_DN_CMP;
				end
			end
			imhq_pkg::S_DN_R: begin
				// right child wins only when strictly smaller
				if ($signed(hrd.key) < $signed(ck_q)) begin
					ck_d   = hrd.key;
					ch_d   = hrd.hdl;
					cidx_d = right[SW-1:0];
				end
				state_d = imhq_pkg::S_DN_CMP;
			end
			imhq_pkg::S_DN_CMP: begin
				if ($signed(ck_q) < $signed(mk_q)) begin
					hwe     = 1'b1;
					hwd     = {ck_q, ch_q};
					pwe     = 1'b1;
					pwa     = ch_q;
					slot_d  = cidx_q;
					state_d = imhq_pkg::S_DN_CHK;
				end else begin
					state_d = imhq_pkg::S_FIN;
				end
			end
			imhq_pkg::S_FIN: begin
				// moving entry lands in the hole
				hwe         = 1'b1;
				pwe         = 1'b1;
				vld_d[mh_q] = 1'b1;
				ov_d        = 1'b1;
				state_d     = imhq_pkg::S_IDLE;
			end
			default: begin
				state_d = imhq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imhq_pkg::S_IDLE;
			count_q <= '0;
			vld_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_q   <= vld_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q  <= slot_d;
		mk_q    <= mk_d;
		mh_q    <= mh_d;
		ck_q    <= ck_d;
		ch_q    <= ch_d;
		cidx_q  <= cidx_d;
		first_q <= first_d;
		st_q    <= st_d;
		ok_q    <= ok_d;
		oh_q    <= oh_d;
	end

	assign out_valid  = ov_q;
	assign status     = st_q;
	assign out_key    = ok_q;
	assign out_handle = oh_q;
	assign count      = count_q;

endmodule

[test/imhq_checker.sv]
// checker for the indexed min-heap queue: watches both channels, predicts and compares results
module imhq_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic signed [imhq_pkg::KEY_W-1:0] new_key,
	input  logic [imhq_pkg::HANDLE_W-1:0]     handle,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [2:0]                        status,
	input  logic signed [imhq_pkg::KEY_W-1:0] out_key,
	input  logic [imhq_pkg::HANDLE_W-1:0]     out_handle,
	input  logic [imhq_pkg::CNT_W-1:0]        count,
	output int                                errors,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KW  = imhq_pkg::KEY_W;
	localparam int HW  = imhq_pkg::HANDLE_W;
	localparam int CW  = imhq_pkg::CNT_W;
	localparam int CAP = imhq_pkg::CAPACITY;
	localparam int HC  = imhq_pkg::HANDLE_COUNT;

	typedef struct {
		imhq_pkg::status_t st;
		logic [KW-1:0]     key;
		logic [HW-1:0]     hdl;
		logic [CW-1:0]     cnt;
	} answer_t;

	logic signed [KW-1:0] keys [CAP];
	logic [HW-1:0]        hdls [CAP];
	int                   where [HC];
	int                   fill;
	answer_t              answers [$];

	assign pending = answers.size();

	function automatic void place(int s, logic signed [KW-1:0] k, logic [HW-1:0] h);
		keys[s] = k;
		hdls[s] = h;
		where[h] = s;
	endfunction

	function automatic void climb(int s, logic signed [KW-1:0] k, logic [HW-1:0] h);
		int p;
		while (s > 0) begin
			p = (s - 1) >> 1;
			if (!(k < keys[p])) break;
			place(s, keys[p], hdls[p]);
			s = p;
		end
		place(s, k, h);
	endfunction

	function automatic void sink(int s, logic signed [KW-1:0] k, logic [HW-1:0] h);
		int c;
		while (s < (fill >> 1)) begin
			c = 2 * s + 1;
			if (c + 1 < fill && keys[c + 1] < keys[c]) c = c + 1;
			if (!(keys[c] < k)) break;
			place(s, keys[c], hdls[c]);
			s = c;
		end
		place(s, k, h);
	endfunction

	function automatic bit queued(logic [HW-1:0] h);
		return where[h] < fill && hdls[where[h]] == h;
	endfunction

	function automatic answer_t heap_step(imhq_pkg::op_t op, logic signed [KW-1:0] k,
			logic [HW-1:0] h);
		answer_t a;
		int s, last;
		a = '{imhq_pkg::ST_OK, '0, '0, '0};
		case (op)
			imhq_pkg::OP_PUSH: begin
				if (queued(h)) a.st = imhq_pkg::ST_DUP;
				else if (fill >= CAP) a.st = imhq_pkg::ST_FULL;
				else begin
					fill++;
					climb(fill - 1, k, h);
				end
			end
			imhq_pkg::OP_POP: begin
				if (fill == 0) a.st = imhq_pkg::ST_EMPTY;
				else begin
					a.key = keys[0];
					a.hdl = hdls[0];
					where[hdls[0]] = CAP;
					fill--;
					if (fill > 0) sink(0, keys[fill], hdls[fill]);
				end
			end
			imhq_pkg::OP_REMOVE: begin
				if (!queued(h)) a.st = imhq_pkg::ST_NOTQ;
				else begin
					s = where[h];
					where[h] = CAP;
					fill--;
					last = fill;
					if (s != last) begin
						// refill may need to go either way
						if (s > 0 && keys[last] < keys[(s - 1) >> 1])
							climb(s, keys[last], hdls[last]);
						else
							sink(s, keys[last], hdls[last]);
					end
				end
			end
			default: ;
		endcase
		a.cnt = CW'(fill);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			fill = 0;
			for (int i = 0; i < HC; i++) where[i] = CAP;
			answers.delete();
			errors = 0;
		end else begin
			if (in_valid && !in_stall)
				answers.push_back(heap_step(imhq_pkg::op_t'(operation), new_key, handle));
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) begin
					$display("%0t unexpected word status=%0d", $time, status);
					errors++;
				end else begin
					e = answers.pop_front();
					if (status !== e.st || out_key !== e.key || out_handle !== e.hdl
							|| count !== e.cnt) begin
						$display("%0t mismatch expected st=%0d key=%0d hdl=%0d cnt=%0d",
							$time, e.st, $signed(e.key), e.hdl, e.cnt,
							" actual st=%0d key=%0d hdl=%0d cnt=%0d",
							status, out_key, out_handle, count);
						errors++;
					end
				end
			end
		end
	end
endmodule

[test/tb_indexed_min_heap_queue.sv]
// stimulus and verdict for the indexed min-heap queue
module tb_indexed_min_heap_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KW = imhq_pkg::KEY_W;
	localparam int HW = imhq_pkg::HANDLE_W;
	localparam int CW = imhq_pkg::CNT_W;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_stall;
	logic [1:0]           operation = imhq_pkg::OP_NONE;
	logic signed [KW-1:0] new_key = '0;
	logic [HW-1:0]        handle = '0;
	logic                 out_valid;
	logic                 out_stall = 1;
	logic [2:0]           status;
	logic signed [KW-1:0] out_key;
	logic [HW-1:0]        out_handle;
	logic [CW-1:0]        count;
	int                   errors, pending;
	bit                   hold_off = 0; // long receiver stall request

	always #6 clk = ~clk;

	indexed_min_heap_queue dut (.*);
	imhq_checker chk (.*);

	// receiver: random stalls, calm stretches, and one long hold-off
	initial begin
		int mode, k;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			mode = $urandom_range(0, 2);
			k = $urandom_range(1, 30);
			repeat (k) begin
				out_stall <= (mode == 0) ? 1'b0 : (mode == 1) ? ($urandom_range(0, 3) == 0)
					: ($urandom_range(0, 1) == 0);
				@(posedge clk);
			end
		end
	end

	// one word, held until taken
	task automatic send(imhq_pkg::op_t op, logic signed [KW-1:0] k, logic [HW-1:0] h);
		in_valid  <= 1;
		operation <= op;
		new_key   <= k;
		handle    <= h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic pause(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// random item biased by a push weight, keys from a narrow or wide range
	task automatic random_word(int push_w);
		int r;
		logic signed [KW-1:0] k;
		r = $urandom_range(0, 99);
		k = ($urandom_range(0, 2) == 0) ? $urandom : $signed($urandom_range(0, 40)) - 20;
		if (r < push_w) send(imhq_pkg::OP_PUSH, k, HW'($urandom));
		else if (r < push_w + 20) send(imhq_pkg::OP_POP, k, HW'($urandom));
		else if (r < 97) send(imhq_pkg::OP_REMOVE, k, HW'($urandom));
		else send(imhq_pkg::OP_NONE, k, HW'($urandom));
	endtask

	initial begin
		int burst;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty cases, extremes, duplicates, removes, unused code
		send(imhq_pkg::OP_POP, 0, 0);
		send(imhq_pkg::OP_REMOVE, 0, 5);
		send(imhq_pkg::OP_PUSH, 32'sh7fffffff, 63);
		send(imhq_pkg::OP_PUSH, 32'sh80000000, 0);
		send(imhq_pkg::OP_PUSH, -1, 21);
		send(imhq_pkg::OP_PUSH, 5, 42);
		send(imhq_pkg::OP_PUSH, 5, 43);
		send(imhq_pkg::OP_PUSH, 1, 63);
		send(imhq_pkg::OP_NONE, 32'sh55555555, 42);
		send(imhq_pkg::OP_REMOVE, 0, 21);
		send(imhq_pkg::OP_REMOVE, 0, 21);
		send(imhq_pkg::OP_POP, 0, 0);
		send(imhq_pkg::OP_POP, 0, 0);
		send(imhq_pkg::OP_POP, 0, 0);
		send(imhq_pkg::OP_POP, 0, 0);
		send(imhq_pkg::OP_POP, 0, 0);
		// fill to capacity, push once more, then pop and remove at random
		for (int i = 0; i < imhq_pkg::HANDLE_COUNT; i++)
			send(imhq_pkg::OP_PUSH, $urandom, HW'(i));
		send(imhq_pkg::OP_PUSH, 0, 7);
		for (int i = 0; i < imhq_pkg::HANDLE_COUNT; i++) begin
			// input keeps offering while the receiver holds off
			if (i == 4) hold_off = 1;
			send(imhq_pkg::OP_PUSH, 0, HW'(63 - i));
		end
		while (hold_off) @(posedge clk);
		for (int i = 0; i < 64; i++)
			send(($urandom_range(0, 1) == 0) ? imhq_pkg::OP_POP : imhq_pkg::OP_REMOVE,
				0, HW'($urandom));
		// random: grow phase, mixed phase, drain phase, in bursts with gaps
		for (int n = 0; n < 260; ) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				random_word(n < 90 ? 70 : n < 200 ? 45 : 15);
				n++;
			end
			if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 25));
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule

[files.f]
rtl/imhq_pkg.sv
rtl/imhq_ram.sv
rtl/indexed_min_heap_queue.sv
test/imhq_checker.sv
test/tb_indexed_min_heap_queue.sv
